// ===== src/optimal_merge_pattern_cost_defines.svh =====
// Assertion macros for the optimal merge pattern block.
// Used by optimal_merge_pattern_cost; expects clk and rst_n in scope.
`ifndef OPTIMAL_MERGE_PATTERN_COST_DEFINES_SVH
`define OPTIMAL_MERGE_PATTERN_COST_DEFINES_SVH

// same-cycle implication, masked during reset
`define OMPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define OMPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/omp_pkg.sv =====
// Shared types and constants for the optimal merge pattern block.
// No dependencies.
package omp_pkg;

  localparam int SIZE_W  = 16;
  localparam int COST_W  = 20;
  localparam int TOTAL_W = 24;

  localparam logic [COST_W-1:0]  COST_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [SIZE_W-1:0] size_value;
    logic              final_item;
  } in_t;

  typedef struct packed {
    logic [COST_W-1:0]  merge_cost;
    logic [TOTAL_W-1:0] running_total;
    logic               overflow;
    logic               last_result;
  } out_t;

  // control from the sequencer to the two-smallest tracker
  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctl_t;

endpackage

// ===== src/omp_scan.sv =====
// Two-smallest tracker: sees one stored value per cycle during a scan and
// keeps the smallest two with their store indices. Depends on omp_pkg.
module omp_scan #(
  parameter int VW = 20,
  parameter int IW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  omp_pkg::scan_ctl_t ctl,
  input  logic [VW-1:0]     in_val,
  input  logic [IW-1:0]     in_idx,
  output logic [VW-1:0]     min1_val,
  output logic [IW-1:0]     min1_idx,
  output logic [VW-1:0]     min2_val,
  output logic [IW-1:0]     min2_idx
);

  logic [VW-1:0] min1_val_r, min1_val_nxt;
  logic [IW-1:0] min1_idx_r, min1_idx_nxt;
  logic [VW-1:0] min2_val_r, min2_val_nxt;
  logic [IW-1:0] min2_idx_r, min2_idx_nxt;

  // stored values never reach all ones, so that serves as "empty"
  always_comb begin
    min1_val_nxt = min1_val_r;
    min1_idx_nxt = min1_idx_r;
    min2_val_nxt = min2_val_r;
    min2_idx_nxt = min2_idx_r;
    priority if (ctl.clr) begin
      min1_val_nxt = '1;
      min1_idx_nxt = '0;
      min2_val_nxt = '1;
      min2_idx_nxt = '0;
    end else if (ctl.vld && (in_val < min1_val_r)) begin
      min2_val_nxt = min1_val_r;
      min2_idx_nxt = min1_idx_r;
      min1_val_nxt = in_val;
      min1_idx_nxt = in_idx;
    end else if (ctl.vld && (in_val < min2_val_r)) begin
      min2_val_nxt = in_val;
      min2_idx_nxt = in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min1_val_r <= '1;
      min1_idx_r <= '0;
      min2_val_r <= '1;
      min2_idx_r <= '0;
    end else begin
      min1_val_r <= min1_val_nxt;
      min1_idx_r <= min1_idx_nxt;
      min2_val_r <= min2_val_nxt;
      min2_idx_r <= min2_idx_nxt;
    end
  end

  assign min1_val = min1_val_r;
  assign min1_idx = min1_idx_r;
  assign min2_val = min2_val_r;
  assign min2_idx = min2_idx_r;

endmodule

// ===== src/optimal_merge_pattern_cost.sv =====
// Optimal merge pattern cost. Each input transaction stores one size;
// sizes past MAX_ITEMS are dropped and flagged. The transaction
// marked final starts the merge phase, during which the block is not
// ready: after a start step per set, each merge of m live values scans
// the store through its single read port, drains the registered read,
// writes the sum back, moves the last entry and presents the result,
// waiting there while the output is stalled. A set of n sizes thus
// gives n - 1 results; a set of one size gives a single zero-cost
// result. The last result carries last_result.
// Depends on omp_pkg, omp_scan and optimal_merge_pattern_cost_defines.svh.
`include "optimal_merge_pattern_cost_defines.svh"

module optimal_merge_pattern_cost #(
  parameter int MAX_ITEMS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  omp_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output omp_pkg::out_t out_data
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int VW = omp_pkg::SIZE_W + IW;
  localparam int SW = (VW > omp_pkg::COST_W) ? VW : omp_pkg::COST_W;
  localparam int TW = omp_pkg::TOTAL_W + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_WSUM  = 7'b0010000,
    S_WLAST = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [omp_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [omp_pkg::COST_W-1:0]  cost_r, cost_nxt;
  logic [IW-1:0] scan_k_r, scan_k_nxt;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic [VW-1:0] rd_data_r;
  logic [VW-1:0] last_val_r, last_val_nxt;
  logic          out_valid_r, out_valid_nxt;
  omp_pkg::out_t out_data_r, out_data_nxt;

  logic [VW-1:0] store_mem [MAX_ITEMS];

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  omp_pkg::scan_ctl_t scan_ctl;
  logic [VW-1:0] min1_val, min2_val;
  logic [IW-1:0] min1_idx, min2_idx;

  logic          in_fire;
  logic          out_load;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] lo_idx, hi_idx;
  logic [VW-1:0] pair_sum;
  logic [SW-1:0] pair_sum_w;
  logic [omp_pkg::COST_W-1:0] pair_cost;
  logic [TW-1:0] total_sum;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign last_idx = IW'(cnt_r - CW'(1));
  assign lo_idx   = (min1_idx < min2_idx) ? min1_idx : min2_idx;
  assign hi_idx   = (min1_idx < min2_idx) ? min2_idx : min1_idx;

  // sums of stored values always fit VW; the reported cost and running total saturate
  assign pair_sum   = min1_val + min2_val;
  assign pair_sum_w = SW'(pair_sum);
  assign pair_cost  = (pair_sum_w > SW'(omp_pkg::COST_MAX)) ?
                      omp_pkg::COST_MAX : omp_pkg::COST_W'(pair_sum_w);
  assign total_sum  = TW'(total_r) + TW'(pair_cost);

  omp_scan #(
    .VW(VW),
    .IW(IW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .in_val   (rd_data_r),
    .in_idx   (cmp_idx_r),
    .min1_val (min1_val),
    .min1_idx (min1_idx),
    .min2_val (min2_val),
    .min2_idx (min2_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    total_nxt     = total_r;
    cost_nxt      = cost_r;
    scan_k_nxt    = scan_k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = lo_idx;
    wr_data       = pair_sum;
    scan_ctl.clr  = 1'b0;
    scan_ctl.vld  = cmp_vld_r;
    // keep the value at the top of the store for the remove step
    last_val_nxt  = (cmp_vld_r && (cmp_idx_r == last_idx)) ? rd_data_r : last_val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            wr_en   = 1'b1;
            wr_addr = IW'(cnt_r);
            wr_data = VW'(in_data.size_value);
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.final_item) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (cnt_r <= CW'(1)) begin
          cost_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          scan_ctl.clr = 1'b1;
          scan_k_nxt   = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_k_nxt = scan_k_r + IW'(1);
        if (scan_k_r == last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WSUM;
      end
      S_WSUM: begin
        // the sum replaces the lower of the two picked entries
        wr_en     = 1'b1;
        wr_addr   = lo_idx;
        wr_data   = pair_sum;
        cost_nxt  = pair_cost;
        total_nxt = total_sum[TW-1] ? omp_pkg::TOTAL_MAX : total_sum[TW-2:0];
        state_nxt = S_WLAST;
      end
      S_WLAST: begin
        // top entry fills the hole left by the higher pick
        if (hi_idx != last_idx) begin
          wr_en   = 1'b1;
          wr_addr = hi_idx;
          wr_data = last_val_r;
        end
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.merge_cost    = cost_r;
          out_data_nxt.running_total = total_r;
          out_data_nxt.overflow      = ovf_r;
          out_data_nxt.last_result   = (cnt_r <= CW'(1));
          if (cnt_r <= CW'(1)) begin
            cnt_nxt   = '0;
            total_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            scan_ctl.clr = 1'b1;
            scan_k_nxt   = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      scan_k_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      total_r     <= total_nxt;
      scan_k_r    <= scan_k_nxt;
      cmp_vld_r   <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cost_r     <= cost_nxt;
    cmp_idx_r  <= scan_k_r;
    last_val_r <= last_val_nxt;
    out_data_r <= out_data_nxt;
  end

  // value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem[scan_k_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OMPC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_ITEMS), "store count above capacity")
  `OMPC_ASSERT_IMP(a_pick_distinct, state_r == S_WSUM, (min1_idx != min2_idx) && (min1_val <= min2_val), "merge picked a bad pair")
  `OMPC_ASSERT_NXT(a_set_end, out_load && (cnt_r <= CW'(1)), (cnt_r == '0) && (total_r == '0) && !ovf_r, "set state not cleared after last result")

endmodule

// ===== tb/optimal_merge_pattern_cost_tb.sv =====
`timescale 1ns / 100ps
// Testbench for optimal_merge_pattern_cost: sets of list sizes in, per-merge costs out,
// checked against an in-bench model of the optimal merge. Depends on omp_pkg and the RTL.
module optimal_merge_pattern_cost_tb;

  localparam int MAX_ITEMS = 16;

  // Keeps the sizes of the open set and, when a set closes, the merge results it must give.
  class merge_cost_board;
    logic [20:0]   live_sizes[$];
    bit            dropped;
    omp_pkg::out_t due_merges[$];
    int            fail_count;
    int            merges_checked;
    int            sets_closed;
    int            overflow_sets;

    function logic [20:0] take_smallest();
      int          best;
      logic [20:0] v;
      best = 0;
      for (int k = 1; k < live_sizes.size(); k++) begin
        if (live_sizes[k] < live_sizes[best]) best = k;
      end
      v = live_sizes[best];
      live_sizes.delete(best);
      return v;
    endfunction

    function void take_size(omp_pkg::in_t item);
      logic [21:0]   sum;
      logic [24:0]   acc;
      logic [23:0]   total;
      omp_pkg::out_t r;
      if (live_sizes.size() < MAX_ITEMS) live_sizes.push_back(21'(item.size_value));
      else dropped = 1'b1;
      if (!item.final_item) return;
      sets_closed++;
      if (dropped) overflow_sets++;
      total = '0;
      if (live_sizes.size() <= 1) begin
        r.merge_cost    = '0;
        r.running_total = '0;
        r.overflow      = dropped;
        r.last_result   = 1'b1;
        due_merges.push_back(r);
      end
      while (live_sizes.size() > 1) begin
        sum = 22'(take_smallest()) + 22'(take_smallest());
        r.merge_cost = (sum > 22'(omp_pkg::COST_MAX)) ?
                       omp_pkg::COST_MAX : sum[omp_pkg::COST_W-1:0];
        acc = 25'(total) + 25'(r.merge_cost);
        total = (acc > 25'(omp_pkg::TOTAL_MAX)) ?
                omp_pkg::TOTAL_MAX : acc[omp_pkg::TOTAL_W-1:0];
        live_sizes.push_back(sum[20:0]);
        r.running_total = total;
        r.overflow      = dropped;
        r.last_result   = (live_sizes.size() == 1);
        due_merges.push_back(r);
      end
      live_sizes.delete();
      dropped = 1'b0;
    endfunction

    function void match_merge(omp_pkg::out_t got);
      omp_pkg::out_t want;
      if (due_merges.size() == 0) begin
        $error("result with nothing outstanding: cost %0d total %0d",
               got.merge_cost, got.running_total);
        fail_count++;
        return;
      end
      want = due_merges.pop_front();
      merges_checked++;
      if (got.merge_cost !== want.merge_cost) begin
        $error("merge_cost: expected %0d, got %0d", want.merge_cost, got.merge_cost);
        fail_count++;
      end
      if (got.running_total !== want.running_total) begin
        $error("running_total: expected %0d, got %0d", want.running_total, got.running_total);
        fail_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        fail_count++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
        fail_count++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  omp_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  omp_pkg::out_t out_data;

  merge_cost_board board = new();
  int send_idle_pct = 17;
  int recv_idle_pct = 68;
  int sizes_sent = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  optimal_merge_pattern_cost #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side: check each transaction, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.match_merge(out_data);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && board.merges_checked >= 30) begin
        // long back-pressure so the merge stalls and input backs up
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_size(input logic [15:0] size, input bit last);
    in_data  <= '{size_value: size, final_item: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.take_size(in_data);
    sizes_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int          set_len;
    int          pick;
    logic [15:0] sz;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // single sizes, a pair of the extremes, then a full set of maximum sizes but one zero, with the final one dropped
    send_size(16'h0000, 1'b1);
    send_size(16'hFFFF, 1'b1);
    send_size(16'h0000, 1'b0);
    send_size(16'hFFFF, 1'b1);
    for (int i = 0; i <= MAX_ITEMS; i++) send_size((i == 3) ? 16'h0000 : 16'hFFFF, i == MAX_ITEMS);

    while (sizes_sent < 520) begin
      if (sizes_sent >= 360) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sizes_sent >= 190) begin
        send_idle_pct = 68;
        recv_idle_pct = 17;
      end
      pick = $urandom_range(9);
      if (pick == 0) set_len = 1;
      else if (pick == 1) set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      else set_len = $urandom_range(2, MAX_ITEMS);
      for (int i = 0; i < set_len; i++) begin
        pick = $urandom_range(9);
        case (pick)
          0: sz = 16'h0000;
          1: sz = 16'hFFFF;
          2, 3: sz = 16'($urandom_range(7));  // small values to force ties
          default: sz = 16'($urandom);
        endcase
        send_size(sz, i == set_len - 1);
      end
    end
    in_valid <= 1'b0;

    while (board.due_merges.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d sizes in %0d sets, %0d of them overflowing the store.",
             sizes_sent, board.sets_closed, board.overflow_sets);
    $display("Checked %0d merge results under three idle mixes and one long output stall.",
             board.merges_checked);
    if (board.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/omp_pkg.sv
src/omp_scan.sv
src/optimal_merge_pattern_cost.sv
tb/optimal_merge_pattern_cost_tb.sv
